// ===== sv/rto_pkg.sv =====
// Shared constants, codes and types for the range table overlap engine.
`default_nettype none
package rto_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int OP_W      = 3;
    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 168;
    localparam int M_DATA_W  = 176;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTAIN = 3'd2;
    localparam logic [OP_W-1:0] OP_OVERLAP = 3'd3;
    localparam logic [OP_W-1:0] OP_FIRST   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLASH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Match rule the back end applies to each slot during its scan
    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_INSERT  = 3'd1;
    localparam logic [2:0] MODE_DELETE  = 3'd2;
    localparam logic [2:0] MODE_CONTAIN = 3'd3;
    localparam logic [2:0] MODE_OVERLAP = 3'd4;
    localparam logic [2:0] MODE_ANY     = 3'd5;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] length;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   hit_start;
        logic [ADDR_W-1:0]   hit_length;
        logic [TAG_W-1:0]    hit_tag;
        logic [CNT_W-1:0]    entry_count;
    } rsp_t;

endpackage
`default_nettype wire

// ===== sv/rto_front.sv =====
// Front end: unpack an incoming request and classify its operation.
`default_nettype none
module rto_front
    import rto_pkg::*;
(
    input  wire logic [S_DATA_W-1:0] in_data,
    output cmd_t                     cmd
);

    logic [OP_W-1:0] op;

    assign op = in_data[OP_W-1:0];

    // Map the operation code onto a scan mode
    always_comb begin
        unique case (op)
            OP_INSERT:  cmd.mode = MODE_INSERT;
            OP_DELETE:  cmd.mode = MODE_DELETE;
            OP_CONTAIN: cmd.mode = MODE_CONTAIN;
            OP_OVERLAP: cmd.mode = MODE_OVERLAP;
            OP_FIRST:   cmd.mode = MODE_ANY;
            default:    cmd.mode = MODE_NONE;
        endcase
    end

    assign cmd.offset = in_data[OP_W +: ADDR_W];
    assign cmd.length = in_data[OP_W+ADDR_W +: ADDR_W];
    assign cmd.tag    = in_data[OP_W+2*ADDR_W +: TAG_W];

endmodule
`default_nettype wire

// ===== sv/rto_queue.sv =====
// Two-entry command queue between front and back end.
`default_nettype none
module rto_queue
    import rto_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = q_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rto_back.sv =====
// Back end: slot memory, sequential scan, update and result register.
`default_nettype none
module rto_back
    import rto_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_avail,
    input  cmd_t      cmd_in,
    output logic      cmd_pop,
    output logic      rsp_valid,
    output rsp_t      rsp,
    input  wire logic rsp_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [1:0]         state_reg, state_next;
    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [ADDR_W-1:0]  rd_start_reg, rd_len_reg;
    logic [TAG_W-1:0]   rd_tag_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]  best_start_reg, best_start_next;
    logic [ADDR_W-1:0]  best_len_reg, best_len_next;
    logic [TAG_W-1:0]   best_tag_reg, best_tag_next;
    logic               clash_reg, clash_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               out_vld_reg, out_vld_next;
    rsp_t               out_reg, out_next;
    logic               mem_we;
    logic               slot_v, slot_match, same_start, ov, contains;

    logic [ADDR_W-1:0] mem_start [ENTRIES];
    logic [ADDR_W-1:0] mem_len   [ENTRIES];
    logic [TAG_W-1:0]  mem_tag   [ENTRIES];

    // x < s + l without wrap
    function automatic logic below_end(input logic [ADDR_W-1:0] x,
                                       input logic [ADDR_W-1:0] s,
                                       input logic [ADDR_W-1:0] l);
        return (x < s) || ((x - s) < l);
    endfunction

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_avail;

    // Evaluate the slot read in the previous cycle
    always_comb begin
        slot_v     = cmp_vld_reg && valid_reg[cmp_idx_reg];
        same_start = (rd_start_reg == cmd_reg.offset);
        ov         = below_end(cmd_reg.offset, rd_start_reg, rd_len_reg)
                  && below_end(rd_start_reg, cmd_reg.offset, cmd_reg.length);
        contains   = (cmd_reg.offset >= rd_start_reg)
                  && ((cmd_reg.offset - rd_start_reg) < rd_len_reg);
        unique case (cmd_reg.mode)
            MODE_DELETE:  slot_match = slot_v && same_start;
            MODE_CONTAIN: slot_match = slot_v && contains;
            MODE_OVERLAP: slot_match = slot_v && ov;
            MODE_ANY:     slot_match = slot_v;
            default:      slot_match = 1'b0;
        endcase
    end

    // Control, scan bookkeeping and final update
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        valid_next      = valid_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_tag_next   = best_tag_reg;
        clash_next      = clash_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        out_vld_next    = out_vld_reg && !rsp_ready;
        out_next        = out_reg;
        mem_we          = 1'b0;

        // Fold in the compared slot
        if (cmp_vld_reg) begin
            if (slot_match && (!hit_reg || rd_start_reg < best_start_reg)) begin
                hit_next        = 1'b1;
                best_idx_next   = cmp_idx_reg;
                best_start_next = rd_start_reg;
                best_len_next   = rd_len_reg;
                best_tag_next   = rd_tag_reg;
            end
            if (slot_v && (same_start || ov)) begin
                clash_next = 1'b1;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_avail) begin
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    clash_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                cmp_vld_next = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_vld_reg || rsp_ready) begin
                    out_vld_next           = 1'b1;
                    out_next.status        = ST_MISSING;
                    out_next.hit_start     = '0;
                    out_next.hit_length    = '0;
                    out_next.hit_tag       = '0;
                    priority if (cmd_reg.mode == MODE_INSERT) begin
                        if (clash_reg) begin
                            out_next.status = ST_CLASH;
                        end else if (!free_found_reg) begin
                            out_next.status = ST_FULL;
                        end else begin
                            out_next.status         = ST_OK;
                            mem_we                  = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            count_next              = count_reg + 1'b1;
                        end
                    end else if (hit_reg) begin
                        out_next.status     = ST_OK;
                        out_next.hit_start  = best_start_reg;
                        out_next.hit_length = best_len_reg;
                        out_next.hit_tag    = best_tag_reg;
                        if (cmd_reg.mode == MODE_DELETE) begin
                            valid_next[best_idx_reg] = 1'b0;
                            count_next               = count_reg - 1'b1;
                        end
                    end else begin
                        // keep the not-found result
                        out_next.status = ST_MISSING;
                    end
                    out_next.entry_count = count_next;
                    state_next           = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Hold scan payload and result
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cmd_reg <= cmd_in;
        end
        idx_reg        <= idx_next;
        cmp_idx_reg    <= idx_reg;
        hit_reg        <= hit_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        best_tag_reg   <= best_tag_next;
        clash_reg      <= clash_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        out_reg        <= out_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_start[free_idx_reg] <= cmd_reg.offset;
            mem_len[free_idx_reg]   <= cmd_reg.length;
            mem_tag[free_idx_reg]   <= cmd_reg.tag;
        end
        rd_start_reg <= mem_start[idx_reg];
        rd_len_reg   <= mem_len[idx_reg];
        rd_tag_reg   <= mem_tag[idx_reg];
    end

endmodule
`default_nettype wire

// ===== sv/range_table_overlap_engine.sv =====
// Top level: range table with front decode, command queue and scanning back end.
// The back end scans the slot memory one slot per cycle through its single read port
// and finishes one request before it takes the next; the queue holds two more.
// Reset: aresetn low clears all valid bits, the count, the queue and the output.
// Slot contents are not cleared; an empty slot is never reported.
`default_nettype none
module range_table_overlap_engine
    import rto_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // operation[2:0], offset[66:3], length[130:67], tag[162:131], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[1:0], hit_start[65:2], hit_length[129:66], hit_tag[161:130],
    // entry_count[168:162], zero pad
    output logic [M_DATA_W-1:0]      m_tdata
);

    cmd_t front_cmd, back_cmd;
    rsp_t rsp;
    logic q_full, q_empty, q_pop, push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    rto_front u_front (
        .in_data (s_tdata),
        .cmd     (front_cmd)
    );

    rto_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (back_cmd),
        .empty    (q_empty)
    );

    rto_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (!q_empty),
        .cmd_in    (back_cmd),
        .cmd_pop   (q_pop),
        .rsp_valid (m_tvalid),
        .rsp       (rsp),
        .rsp_ready (m_tready)
    );

    assign m_tdata = {{(M_DATA_W - $bits(rsp_t)){1'b0}}, rsp.entry_count, rsp.hit_tag,
                      rsp.hit_length, rsp.hit_start, rsp.status};

endmodule
`default_nettype wire

// ===== sv/rto_checker.sv =====
// Port-level checker for the range table engine, bound to the top level.
`default_nettype none
module rto_checker
    import rto_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [CNT_W-1:0]    cnt;

    assign st  = m_tdata[STATUS_W-1:0];
    assign cnt = m_tdata[STATUS_W+2*ADDR_W+TAG_W +: CNT_W];

    // Count never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt <= CNT_W'(ENTRIES)))
        else $error("entry count above table size");

    // Full status only with a full table
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && st == ST_FULL) |-> (cnt == CNT_W'(ENTRIES)))
        else $error("full status with free slots");

    // Hit fields are zero on any failure
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && st != ST_OK) |->
        (m_tdata[STATUS_W +: 2*ADDR_W+TAG_W] == '0))
        else $error("hit fields set on failed request");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind range_table_overlap_engine rto_checker u_rto_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the range table overlap engine.
`default_nettype none
module tb_top;
    import rto_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Fields listed from the highest bits down, so the operation lands in bits 2:0
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] offset;
        logic [OP_W-1:0]   op;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]    entry_count;
        logic [TAG_W-1:0]    hit_tag;
        logic [ADDR_W-1:0]   hit_length;
        logic [ADDR_W-1:0]   hit_start;
        logic [STATUS_W-1:0] status;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    range_table_overlap_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state: a copy of the range table
    logic              tbl_valid [ENTRIES];
    logic [ADDR_W-1:0] tbl_start [ENTRIES];
    logic [ADDR_W-1:0] tbl_len   [ENTRIES];
    logic [TAG_W-1:0]  tbl_tag   [ENTRIES];
    int                tbl_count;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   errors = 0;
    int   results_seen = 0;
    int   accepted = 0;
    bit   stim_done = 1'b0;
    bit   calm = 1'b0;
    bit   long_hold = 1'b0;
    bit   s_took = 1'b0;
    int   op_hits[8];

    // x < s + l without wrap
    function automatic bit below_end(logic [63:0] x, logic [63:0] s, logic [63:0] l);
        return (x < s) || ((x - s) < l);
    endfunction

    function automatic bit ranges_meet(logic [63:0] s1, logic [63:0] l1,
                                       logic [63:0] s2, logic [63:0] l2);
        return below_end(s1, s2, l2) && below_end(s2, s1, l1);
    endfunction

    // Apply one request to the table copy and return its result
    function automatic res_t apply_request(req_t r);
        res_t o;
        int hit;
        int free_slot;
        bit clash;
        bit m;
        o = '0;
        o.status = ST_MISSING;
        hit = -1;
        free_slot = -1;
        clash = 1'b0;
        case (r.op)
            OP_INSERT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_start[i] == r.offset ||
                            ranges_meet(r.offset, r.length, tbl_start[i], tbl_len[i]))
                            clash = 1'b1;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (clash) o.status = ST_CLASH;
                else if (free_slot < 0) o.status = ST_FULL;
                else begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_start[free_slot] = r.offset;
                    tbl_len[free_slot] = r.length;
                    tbl_tag[free_slot] = r.tag;
                    tbl_count++;
                    o.status = ST_OK;
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (hit < 0 && tbl_valid[i] && tbl_start[i] == r.offset) hit = i;
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    tbl_count--;
                end
            end
            OP_CONTAIN, OP_OVERLAP, OP_FIRST: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (r.op == OP_CONTAIN)
                            m = r.offset >= tbl_start[i] &&
                                below_end(r.offset, tbl_start[i], tbl_len[i]);
                        else if (r.op == OP_OVERLAP)
                            m = ranges_meet(r.offset, r.length, tbl_start[i], tbl_len[i]);
                        else
                            m = 1'b1;
                        if (m && (hit < 0 || tbl_start[i] < tbl_start[hit])) hit = i;
                    end
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            o.status = ST_OK;
            o.hit_start = tbl_start[hit];
            o.hit_length = tbl_len[hit];
            o.hit_tag = tbl_tag[hit];
        end
        o.entry_count = tbl_count[CNT_W-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
        errors++;
    endtask

    function automatic req_t mk(logic [OP_W-1:0] op, logic [63:0] off,
                                logic [63:0] len, logic [31:0] tag);
        req_t r;
        r.op = op;
        r.offset = off;
        r.length = len;
        r.tag = tag;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick a start near a small cluster so ranges collide often
    function automatic logic [63:0] near_start(logic [63:0] base);
        return base + 64'($urandom_range(0, 4095));
    endfunction

    // Driver: present the head of the queue, with random idle bursts
    int src_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            // Hold an offered request until it is taken
            if (!s_tvalid || s_took) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !calm &&
                             $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 17);
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= S_DATA_W'(pending_reqs[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            s_took = 1'b0;
        end
    end

    // Predict on each accepted request and retire it from the queue
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            req_t r;
            r = req_t'(s_tdata[$bits(req_t)-1:0]);
            op_hits[r.op]++;
            expected_results.push_back(apply_request(r));
            void'(pending_reqs.pop_front());
            accepted++;
            s_took = 1'b1;
        end
    end

    // Receiver stall bursts; long_hold keeps tready low
    int snk_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_hold) m_tready <= 1'b0;
            else if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            res_t got;
            res_t want;
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(got.status), 64'(0));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.hit_start !== want.hit_start)
                    report_mismatch("hit_start", got.hit_start, want.hit_start);
                if (got.hit_length !== want.hit_length)
                    report_mismatch("hit_length", got.hit_length, want.hit_length);
                if (got.hit_tag !== want.hit_tag)
                    report_mismatch("hit_tag", 64'(got.hit_tag), 64'(want.hit_tag));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // Stimulus
    initial begin
        logic [63:0] base;
        logic [63:0] starts[$];
        int pick;
        int n;
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, extremes, zero length, clashes, unknown codes
        pending_reqs.push_back(mk(OP_FIRST, 0, 0, 0));
        pending_reqs.push_back(mk(OP_CONTAIN, 5, 0, 0));
        pending_reqs.push_back(mk(OP_OVERLAP, 0, '1, 0));
        pending_reqs.push_back(mk(OP_DELETE, 7, 0, 0));
        pending_reqs.push_back(mk(OP_INSERT, '1, '1, '1));
        pending_reqs.push_back(mk(OP_INSERT, 0, 0, 32'h1));
        pending_reqs.push_back(mk(OP_INSERT, 0, 10, 32'h2));
        pending_reqs.push_back(mk(OP_INSERT, 100, 50, 32'hA5A5_5A5A));
        pending_reqs.push_back(mk(OP_INSERT, 120, 0, 32'h3));
        pending_reqs.push_back(mk(OP_INSERT, 150, 0, 32'h4));
        pending_reqs.push_back(mk(OP_INSERT, 140, 20, 32'h5));
        pending_reqs.push_back(mk(OP_OVERLAP, 125, 0, 0));
        pending_reqs.push_back(mk(OP_OVERLAP, 0, '1, 0));
        pending_reqs.push_back(mk(OP_CONTAIN, 149, 0, 0));
        pending_reqs.push_back(mk(OP_CONTAIN, 150, 0, 0));
        pending_reqs.push_back(mk(OP_CONTAIN, '1, 0, 0));
        pending_reqs.push_back(mk(OP_FIRST, 0, 0, 0));
        pending_reqs.push_back(mk(3'd5, '1, '1, '1));
        pending_reqs.push_back(mk(3'd7, 0, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, 100, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, 100, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, '1, 0, 0));
        pending_reqs.push_back(mk(OP_FIRST, 0, 0, 0));

        // Fill the table to capacity, refuse the last four, then keep tready low a while
        for (int i = 0; i < ENTRIES + 2; i++)
            pending_reqs.push_back(mk(OP_INSERT, 64'h1000_0000 + 64'(i) * 16, 16, $urandom));
        while (pending_reqs.size() > 8) @(negedge aclk);
        long_hold = 1'b1;
        repeat (1500) @(negedge aclk);
        long_hold = 1'b0;

        // Sender pause: wait for every result, then empty the table
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        for (int i = 0; i < ENTRIES; i++)
            pending_reqs.push_back(mk(OP_DELETE, 64'h1000_0000 + 64'(i) * 16, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, 0, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, '1, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, 120, 0, 0));
        pending_reqs.push_back(mk(OP_DELETE, 150, 0, 0));

        // Random: clustered ranges so inserts clash and fill, mixed with queries
        n = 0;
        while (n < 1400) begin
            req_t r;
            if (n % 300 == 0) base = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom);
            r = mk(3'($urandom_range(0, 4)), near_start(base),
                   64'($urandom_range(0, 200)), $urandom);
            if ($urandom_range(0, 19) == 0) r.length = rand64();
            if ($urandom_range(0, 29) == 0) r.offset = rand64();
            if ($urandom_range(0, 49) == 0) r.op = 3'($urandom_range(5, 7));
            if (r.op == OP_INSERT) starts.push_back(r.offset);
            if ((r.op == OP_DELETE || r.op == OP_CONTAIN) && starts.size() > 0 &&
                $urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, starts.size() - 1);
                r.offset = starts[pick] + ((r.op == OP_CONTAIN) ? 64'($urandom_range(0, 3)) : 0);
            end
            pending_reqs.push_back(r);
            n++;
            if (n == 1200) begin
                wait (pending_reqs.size() == 0);
                calm = 1'b1;
            end
            while (pending_reqs.size() > 20) @(negedge aclk);
        end
        wait (pending_reqs.size() == 0);
        stim_done = 1'b1;
    end

    // Finish once drained
    initial begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        $display("covered %0d requests: insert %0d delete %0d contain %0d overlap %0d first %0d",
                 accepted, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4]);
        $display("including full-table refusals, clashes, zero lengths and unknown codes");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
